/* hdl/amw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the aging median window block.
package amw_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STAMP_W  = 32;
    localparam int MODE_W   = 2;
    localparam int AGE_W    = 16;
    localparam int MINCNT_W = 4;
    localparam int FILL_W   = 4;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;
    localparam int REGIDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [REGIDX_W-1:0] REG_MAX_AGE    = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_MIN_COUNT  = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_CLAMP_LOW  = 2'd2;
    localparam logic [REGIDX_W-1:0] REG_CLAMP_HIGH = 2'd3;

    localparam logic [AGE_W-1:0]    RST_MAX_AGE    = 16'd5;
    localparam logic [MINCNT_W-1:0] RST_MIN_COUNT  = 4'd6;
    localparam logic [SAMPLE_W-1:0] RST_CLAMP_LOW  = 16'd650;
    localparam logic [SAMPLE_W-1:0] RST_CLAMP_HIGH = 16'd3500;

    typedef struct packed {
        logic [AGE_W-1:0]    max_age;
        logic [MINCNT_W-1:0] min_count;
        logic [SAMPLE_W-1:0] clamp_low;
        logic [SAMPLE_W-1:0] clamp_high;
    } amw_cfg_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic load_sort;
        logic sort_step;
        logic sort_odd;
        logic load_out;
    } amw_cmd_t;

    typedef struct packed {
        logic out_busy;
    } amw_sts_t;

endpackage

/* hdl/aging_median_window.sv */
`timescale 1ns / 1ps
// Top level of the aging median window: running median with age eviction.
//
// Each transaction (push, tick or clear) yields one result transaction carrying the
// median, its valid flag, the fill count and the eviction flag. One transaction is
// in flight at a time. After acceptance it steps through an update, a sort load, the
// sort passes and a done step, which loads the result into the output register. The
// odd-even transposition sort runs one pass per cycle over all WINDOW_DEPTH window
// entries. A finished result sits in an output register, so the next transaction is
// accepted while the result waits; that transaction then holds in its last step until
// the waiting result is taken. Configuration is written through the APB port only
// while the block is idle, a rule for the user that the block itself does not enforce.
// Registers at byte offsets 0x0 max_age, 0x4 min_count, 0x8 clamp_low and 0xC clamp_high.
module aging_median_window
    import amw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [STAMP_W-1:0]  now,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] median_value,
    output logic                median_valid,
    output logic [FILL_W-1:0]   fill_count,
    output logic                evicted
);

    amw_cfg_t cfg;
    amw_cmd_t cmd;
    amw_sts_t sts;

    amw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    amw_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    amw_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .sample       (sample),
        .now          (now),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median_value (median_value),
        .median_valid (median_valid),
        .fill_count   (fill_count),
        .evicted      (evicted)
    );

endmodule

/* hdl/amw_regs.sv */
`timescale 1ns / 1ps
// APB configuration registers of the aging median window.
module amw_regs
    import amw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    output amw_cfg_t            cfg
);

    amw_cfg_t            cfg_reg;
    logic                wr_en;
    logic [REGIDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_age    <= RST_MAX_AGE;
            cfg_reg.min_count  <= RST_MIN_COUNT;
            cfg_reg.clamp_low  <= RST_CLAMP_LOW;
            cfg_reg.clamp_high <= RST_CLAMP_HIGH;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAX_AGE:    cfg_reg.max_age    <= pwdata[AGE_W-1:0];
                REG_MIN_COUNT:  cfg_reg.min_count  <= pwdata[MINCNT_W-1:0];
                REG_CLAMP_LOW:  cfg_reg.clamp_low  <= pwdata[SAMPLE_W-1:0];
                REG_CLAMP_HIGH: cfg_reg.clamp_high <= pwdata[SAMPLE_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAX_AGE:    prdata = APB_DW'(cfg_reg.max_age);
            REG_MIN_COUNT:  prdata = APB_DW'(cfg_reg.min_count);
            REG_CLAMP_LOW:  prdata = APB_DW'(cfg_reg.clamp_low);
            REG_CLAMP_HIGH: prdata = APB_DW'(cfg_reg.clamp_high);
            default:        prdata = '0;
        endcase
    end

endmodule

/* hdl/amw_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the aging median window.
module amw_ctrl
    import amw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 13
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  amw_sts_t sts,
    output amw_cmd_t cmd
);

    localparam int PW = $clog2(WINDOW_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_SORT   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [PW-1:0] pass_reg;
    logic [PW-1:0] pass_next;
    logic          last_pass;

    assign last_pass = (pass_reg == PW'(WINDOW_DEPTH - 1));

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_sort = 1'b1;
                pass_next     = '0;
                state_next    = ST_SORT;
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = pass_reg[0];
                if (last_pass)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pass_next = pass_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

/* hdl/amw_dp.sv */
`timescale 1ns / 1ps
// Window storage, sorting network and output register of the aging median window.
module amw_dp
    import amw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  amw_cfg_t            cfg,
    input  amw_cmd_t            cmd,
    output amw_sts_t            sts,
    input  logic [MODE_W-1:0]   mode,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [STAMP_W-1:0]  now,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] median_value,
    output logic                median_valid,
    output logic [FILL_W-1:0]   fill_count,
    output logic                evicted
);

    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int IW   = $clog2(WINDOW_DEPTH);
    localparam int CMPW = (CW > MINCNT_W) ? CW : MINCNT_W;
    localparam int MID_ODD     = (WINDOW_DEPTH % 2 == 1) ? (WINDOW_DEPTH - 1) / 2
                                                         : (WINDOW_DEPTH - 2) / 2;
    localparam int MID_EVEN_LO = (WINDOW_DEPTH % 2 == 1) ? (WINDOW_DEPTH - 3) / 2
                                                         : (WINDOW_DEPTH - 2) / 2;
    localparam int MID_EVEN_HI = (WINDOW_DEPTH % 2 == 1) ? (WINDOW_DEPTH - 1) / 2
                                                         : WINDOW_DEPTH / 2;

    logic [MODE_W-1:0]   mode_reg;
    logic [SAMPLE_W-1:0] sample_in_reg;
    logic [STAMP_W-1:0]  now_reg;

    logic [SAMPLE_W-1:0] sample_reg [WINDOW_DEPTH];
    logic [STAMP_W-1:0]  stamp_reg  [WINDOW_DEPTH];
    logic [CW-1:0]       count_reg;
    logic                evict_reg;

    logic [SAMPLE_W-1:0] sort_reg  [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] sort_next [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] pad_fill  [WINDOW_DEPTH];

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] median_value_reg;
    logic                median_valid_reg;
    logic [FILL_W-1:0]   fill_count_reg;
    logic                evicted_reg;

    logic [SAMPLE_W-1:0] clamped;
    logic                do_push;
    logic [CW-1:0]       last_cnt;
    logic [IW-1:0]       last_idx;
    logic [STAMP_W:0]    age_limit;
    logic                do_evict;
    logic [CW-1:0]       pad_low;
    logic [SAMPLE_W:0]   mid_sum;
    logic [SAMPLE_W-1:0] median_calc;

    assign sts.out_busy = out_valid_reg && !out_ready;

    // clamp high first, then low
    always_comb
    begin
        if (sample_in_reg > cfg.clamp_high)
        begin
            clamped = cfg.clamp_high;
        end
        else if (sample_in_reg < cfg.clamp_low)
        begin
            clamped = cfg.clamp_low;
        end
        else
        begin
            clamped = sample_in_reg;
        end
    end

    assign do_push   = (mode_reg == MODE_PUSH) && (sample_in_reg != '0);
    assign last_cnt  = count_reg - 1'b1;
    assign last_idx  = last_cnt[IW-1:0];
    assign age_limit = {1'b0, stamp_reg[last_idx]} + (STAMP_W + 1)'(cfg.max_age);
    assign do_evict  = (mode_reg == MODE_TICK) && (count_reg != '0)
                       && (age_limit < {1'b0, now_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg      <= mode;
            sample_in_reg <= sample;
            now_reg       <= now;
        end
        if (cmd.update)
        begin
            evict_reg <= do_evict;
            if (do_push)
            begin
                for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                begin
                    sample_reg[i] <= sample_reg[i-1];
                    stamp_reg[i]  <= stamp_reg[i-1];
                end
                sample_reg[0] <= clamped;
                stamp_reg[0]  <= now_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            case (mode_reg)
                MODE_PUSH:
                begin
                    if (do_push && (count_reg < CW'(WINDOW_DEPTH)))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    if (do_evict)
                    begin
                        count_reg <= last_cnt;
                    end
                end
                MODE_CLEAR:
                begin
                    count_reg <= '0;
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // pad empty slots so the median lands on fixed positions
    assign pad_low = CW'(WINDOW_DEPTH) - count_reg;

    always_comb
    begin
        logic [CW-1:0] pad_idx;
        logic [CW-1:0] pad_half;
        pad_half = pad_low >> 1;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            pad_idx = CW'(i) - count_reg;
            if (CW'(i) < count_reg)
            begin
                pad_fill[i] = sample_reg[i];
            end
            else if (pad_idx < pad_half)
            begin
                pad_fill[i] = '0;
            end
            else
            begin
                pad_fill[i] = '1;
            end
        end
    end

    // odd-even transposition pass
    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            sort_next[i] = sort_reg[i];
        end
        for (int i = 0; i < WINDOW_DEPTH - 1; i++)
        begin
            if ((((i % 2) != 0) == cmd.sort_odd) && (sort_reg[i] > sort_reg[i+1]))
            begin
                sort_next[i]   = sort_reg[i+1];
                sort_next[i+1] = sort_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sort)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                sort_reg[i] <= pad_fill[i];
            end
        end
        else if (cmd.sort_step)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                sort_reg[i] <= sort_next[i];
            end
        end
    end

    assign mid_sum = {1'b0, sort_reg[MID_EVEN_LO]} + {1'b0, sort_reg[MID_EVEN_HI]};

    always_comb
    begin
        if (count_reg == '0)
        begin
            median_calc = '0;
        end
        else if (count_reg[0])
        begin
            median_calc = sort_reg[MID_ODD];
        end
        else
        begin
            median_calc = mid_sum[SAMPLE_W:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            median_value_reg <= median_calc;
            median_valid_reg <= CMPW'(count_reg) > CMPW'(cfg.min_count);
            fill_count_reg   <= FILL_W'(count_reg);
            evicted_reg      <= evict_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_value = median_value_reg;
    assign median_valid = median_valid_reg;
    assign fill_count   = fill_count_reg;
    assign evicted      = evicted_reg;

endmodule

/* hdl/amw_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the aging median window, bound to the top level.
module amw_checker
    import amw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 13
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [APB_AW-1:0]   paddr,
    input logic [APB_DW-1:0]   pwdata,
    input logic [APB_DW-1:0]   prdata,
    input logic                pready,
    input logic                in_valid,
    input logic                in_ready,
    input logic [MODE_W-1:0]   mode,
    input logic [SAMPLE_W-1:0] sample,
    input logic [STAMP_W-1:0]  now,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SAMPLE_W-1:0] median_value,
    input logic                median_valid,
    input logic [FILL_W-1:0]   fill_count,
    input logic                evicted
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("transaction accepted while another is in flight");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((WINDOW_DEPTH > 15) || (32'(fill_count) <= WINDOW_DEPTH)))
        else $error("fill count exceeds window depth");

    a_empty_median: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (fill_count == '0) && (WINDOW_DEPTH <= 15))
        |-> ((median_value == '0) && !median_valid))
        else $error("empty window reports a median");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready)
        |=> (out_valid && $stable(median_value) && $stable(fill_count) && $stable(evicted)))
        else $error("stalled result changed");

endmodule

bind aging_median_window amw_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_amw_checker (.*);
